@@ hdl/aebu_pkg.sv @@
// Shared types, codes and helpers for the ADC event block unpacker.
`timescale 1ns / 1ps

package aebu_pkg;

  localparam int unsigned MAX_MODULES_DEF = 4;
  localparam int unsigned CHANNELS        = 32;
  localparam int unsigned CHAN_W          = $clog2(CHANNELS);

  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_EMPTY   = 8'b0000_0010,
    PH_ADDR    = 8'b0000_0100,
    PH_VAL     = 8'b0000_1000,
    PH_CHAN    = 8'b0001_0000,
    PH_COUNTER = 8'b0010_0000,
    PH_TRAILER = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    RPT_HIT      = 3'd0,
    RPT_MISMATCH = 3'd1,
    RPT_COUNTER  = 3'd2,
    RPT_EVENT_OK = 3'd3,
    RPT_LEN_ERR  = 3'd4
  } rpt_e;

  typedef enum logic [1:0] {
    CFG_FIRST_COUNT  = 2'd0,
    CFG_SECOND_COUNT = 2'd1,
    CFG_FIRST_ADDR   = 2'd2,
    CFG_SECOND_ADDR  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  first_count;
    logic [2:0]  second_count;
    logic [19:0] first_addr;
    logic [31:0] second_addr;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        slot;
    logic [CHAN_W-1:0] channel;
    logic [15:0]       value;
    rpt_e              code;
    logic              eoe;
  } result_t;

  // Up to two results per word, packed toward e0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t e0;
    result_t e1;
  } push_t;

  function automatic result_t mk_result(logic kind, logic [2:0] slot,
                                        logic [CHAN_W-1:0] channel,
                                        logic [15:0] value, rpt_e code, logic eoe);
    result_t r;
    r.kind    = kind;
    r.slot    = slot[1:0];
    r.channel = channel;
    r.value   = value;
    r.code    = code;
    r.eoe     = eoe;
    return r;
  endfunction

  // Configured address of a module; slots past the register read as zero.
  function automatic logic [7:0] expected_addr(logic kind, logic [2:0] slot, cfg_t cfg);
    logic [7:0] a;
    a = '0;
    if (!slot[2]) begin
      if (kind) begin
        a = cfg.second_addr[8*slot[1:0] +: 8];
      end else begin
        a = {3'b000, cfg.first_addr[5*slot[1:0] +: 5]};
      end
    end
    return a;
  endfunction

endpackage

@@ hdl/aebu_if.sv @@
// Valid/ready channel interfaces for event words and results.
`timescale 1ns / 1ps

interface aebu_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_word;
  logic        final_word;

  modport source (output valid, event_word, final_word, input ready);
  modport sink   (input valid, event_word, final_word, output ready);
endinterface

interface aebu_result_if;
  logic        valid;
  logic        ready;
  logic        module_kind;
  logic [1:0]  module_slot;
  logic [4:0]  channel_number;
  logic [15:0] word_value;
  logic [2:0]  report_code;
  logic        end_of_event;

  modport source (output valid, module_kind, module_slot, channel_number, word_value,
                  report_code, end_of_event, input ready);
  modport sink   (input valid, module_kind, module_slot, channel_number, word_value,
                  report_code, end_of_event, output ready);
endinterface

@@ hdl/adc_event_block_unpacker.sv @@
// Path: a word's first result passes through the word reg and then the result queue.
// Throughput: one word per cycle while the result queue has room; the queue drains one beat
//   per cycle, so words giving two results (a hit, mismatch or counter plus the closing status) fill it faster.
// Backpressure enters through the three-entry result queue, which needs two free entries.
// Reset (rst_ni, async, active low) clears config registers to zero and rewinds the parser
//   to the first module header; the queue and word register come up empty.
`timescale 1ns / 1ps

module adc_event_block_unpacker import aebu_pkg::*; #(
  parameter int unsigned MAX_MODULES_PER_KIND = MAX_MODULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  aebu_word_if.sink     evt_i,
  aebu_result_if.source res_o
);

  // Config registers. To be written by the user only between events; the block does not
  // enforce this. The parser uses the current counts and addresses combinationally.
  cfg_t  cfg_q;

  push_t push;
  logic  room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_count  <= 3'd0;
      cfg_q.second_count <= 3'd0;
      cfg_q.first_addr   <= 20'd0;
      cfg_q.second_addr  <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FIRST_COUNT:  cfg_q.first_count  <= cfg_data_i[2:0];
        CFG_SECOND_COUNT: cfg_q.second_count <= cfg_data_i[2:0];
        CFG_FIRST_ADDR:   cfg_q.first_addr   <= cfg_data_i[19:0];
        CFG_SECOND_ADDR:  cfg_q.second_addr  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Parser: registers the incoming beat, then walks header (or empty mark) / address /
  // data pairs / counter / trailer for each module, one word per cycle while the queue has room.
  aebu_parser #(
    .MAX_MODULES_PER_KIND(MAX_MODULES_PER_KIND)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .room_i (room),
    .push_o (push),
    .evt_i  (evt_i)
  );

  // Result queue: decouples the output side so the parser keeps taking
  // words while earlier results wait.
  aebu_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

@@ hdl/aebu_parser.sv @@
// Word register and parse state machine taking one word per cycle while the queue has room.
`timescale 1ns / 1ps

module aebu_parser import aebu_pkg::*; #(
  parameter int unsigned MAX_MODULES_PER_KIND = MAX_MODULES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic room_i,
  output push_t push_o,
  aebu_word_if.sink evt_i
);

  localparam logic [3:0] MaxMods = 4'(MAX_MODULES_PER_KIND);

  typedef struct packed {
    phase_e     phase;
    logic       kind;
    logic [2:0] slot;
  } pos_t;

  function automatic logic [2:0] sat_count(logic [2:0] n);
    logic [2:0] r;
    r = n;
    if ({1'b0, n} > MaxMods) begin
      r = MaxMods[2:0];
    end
    return r;
  endfunction

  // Skip to the next module that exists, or to done.
  function automatic pos_t normalize(pos_t p, logic [2:0] c0, logic [2:0] c1);
    pos_t r;
    r = p;
    if (p.phase == PH_HEADER) begin
      if (!r.kind && r.slot >= c0) begin
        r.kind = 1'b1;
        r.slot = 3'd0;
      end
      if (r.kind && r.slot >= c1) begin
        r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

  logic        in_v_q;
  logic [15:0] word_q;
  logic        fin_q;
  logic        fire;

  pos_t        pos_q, pos_d;
  logic [12:0] wl_q, wl_d;
  logic        skip_q, skip_d;
  logic [11:0] held_q, held_d;

  pos_t        cur, nm, nxt;
  logic [2:0]  cnt0, cnt1;
  logic [12:0] wl_dec, wl_adr;
  logic [7:0]  addr_rx;
  logic        mism, consumed, has_a;
  result_t     a_res, fin_res;
  rpt_e        fin_code;

  assign fire        = in_v_q && room_i;
  assign evt_i.ready = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_v_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      word_q <= evt_i.event_word;
      fin_q  <= evt_i.final_word;
    end
  end

  always_comb begin
    cnt0     = sat_count(cfg_i.first_count);
    cnt1     = sat_count(cfg_i.second_count);
    cur      = normalize(pos_q, cnt0, cnt1);
    nm       = cur;
    nxt      = cur;
    wl_d     = wl_q;
    skip_d   = skip_q;
    held_d   = held_q;
    consumed = 1'b1;
    has_a    = 1'b0;
    wl_dec   = (wl_q != 13'd0) ? wl_q - 13'd1 : 13'd0;
    wl_adr   = wl_q;
    addr_rx  = cur.kind ? word_q[7:0] : {3'b000, word_q[15:11]};
    mism     = addr_rx != expected_addr(cur.kind, cur.slot, cfg_i);
    a_res    = mk_result(cur.kind, cur.slot, '0, {8'h00, addr_rx}, RPT_MISMATCH, 1'b0);

    // next_module target
    nm.phase = PH_HEADER;
    nm.slot  = cur.slot + 3'd1;

    case (cur.phase)
      PH_HEADER: begin
        if (word_q == EMPTY_MARK) begin
          nxt.phase = PH_EMPTY;
        end else begin
          wl_d = cur.kind ? {word_q[11:0], 1'b0} : {4'b0000, word_q[15:8], 1'b0};
          nxt.phase = PH_ADDR;
        end
      end
      PH_EMPTY: begin
        nxt = normalize(nm, cnt0, cnt1);
      end
      PH_ADDR: begin
        if (cur.kind) begin
          wl_adr = (wl_q >= 13'd2) ? wl_q - 13'd2 : 13'd0;
        end
        wl_d      = wl_adr;
        skip_d    = mism;
        has_a     = mism;
        nxt.phase = (wl_adr != 13'd0) ? PH_VAL : PH_COUNTER;
      end
      PH_VAL: begin
        held_d    = word_q[11:0];
        wl_d      = wl_dec;
        nxt.phase = PH_CHAN;
      end
      PH_CHAN: begin
        wl_d      = wl_dec;
        has_a     = !skip_q;
        a_res     = mk_result(cur.kind, cur.slot, word_q[CHAN_W-1:0], {4'h0, held_q},
                              RPT_HIT, 1'b0);
        nxt.phase = (wl_dec != 13'd0) ? PH_VAL : PH_COUNTER;
      end
      PH_COUNTER: begin
        has_a     = 1'b1;
        a_res     = mk_result(cur.kind, cur.slot, '0, word_q, RPT_COUNTER, 1'b0);
        skip_d    = 1'b0;
        wl_d      = 13'd3;
        nxt.phase = PH_TRAILER;
      end
      PH_TRAILER: begin
        wl_d = wl_dec;
        if (wl_dec == 13'd0) begin
          nxt = normalize(nm, cnt0, cnt1);
        end
      end
      default: begin
        consumed = 1'b0;
      end
    endcase

    fin_code = (consumed && nxt.phase == PH_DONE) ? RPT_EVENT_OK : RPT_LEN_ERR;
    fin_res  = mk_result(1'b0, 3'd0, '0, 16'h0000, fin_code, 1'b1);

    pos_d = nxt;
    if (fin_q) begin
      pos_d.phase = PH_HEADER;
      pos_d.kind  = 1'b0;
      pos_d.slot  = 3'd0;
      wl_d        = 13'd0;
      skip_d      = 1'b0;
      held_d      = 12'd0;
    end

    push_o.v0 = fire && (has_a || fin_q);
    push_o.v1 = fire && has_a && fin_q;
    push_o.e0 = has_a ? a_res : fin_res;
    push_o.e1 = fin_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q.phase <= PH_HEADER;
      pos_q.kind  <= 1'b0;
      pos_q.slot  <= 3'd0;
      wl_q        <= 13'd0;
      skip_q      <= 1'b0;
      held_q      <= 12'd0;
    end else if (fire) begin
      pos_q  <= pos_d;
      wl_q   <= wl_d;
      skip_q <= skip_d;
      held_q <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> (push_o.e1.eoe && !push_o.e0.eoe))
    else $error("closing status not last in beat pair");

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && fin_q) |=> (pos_q.phase == PH_HEADER && !pos_q.kind && pos_q.slot == 3'd0
                         && wl_q == 13'd0 && !skip_q))
    else $error("parser not rewound after final word");

  a_trailer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q.phase == PH_TRAILER) |-> (wl_q != 13'd0 && wl_q <= 13'd3))
    else $error("trailer word count out of range");
`endif

endmodule

@@ hdl/aebu_out_queue.sv @@
// Three-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps

module aebu_out_queue import aebu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  aebu_result_if.source res_o
);

  localparam int unsigned Depth = 3;

  result_t    q_q [Depth];
  result_t    q_d [Depth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  always_comb begin
    pop    = (cnt_q != 2'd0) && res_o.ready;
    base   = cnt_q - 2'(pop);
    room_o = base <= 2'd1;

    for (int i = 0; i < Depth - 1; i++) begin
      q_d[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_d[Depth-1] = q_q[Depth-1];

    for (int i = 0; i < Depth; i++) begin
      if (push_i.v0 && base == 2'(i)) begin
        q_d[i] = push_i.e0;
      end
      if (push_i.v1 && (base + 2'd1) == 2'(i)) begin
        q_d[i] = push_i.e1;
      end
    end

    cnt_d = base + 2'(push_i.v0) + 2'(push_i.v1);
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign res_o.valid          = cnt_q != 2'd0;
  assign res_o.module_kind    = q_q[0].kind;
  assign res_o.module_slot    = q_q[0].slot;
  assign res_o.channel_number = q_q[0].channel;
  assign res_o.word_value     = q_q[0].value;
  assign res_o.report_code    = q_q[0].code;
  assign res_o.end_of_event   = q_q[0].eoe;

`ifndef SYNTHESIS
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> push_i.v0)
    else $error("second beat pushed without first");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> (3'(base) + 3'(push_i.v0) + 3'(push_i.v1) <= 3'(Depth)))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room_o |-> !push_i.v0)
    else $error("push while queue reports no room");
`endif

endmodule

@@ tb/sv/aebu_unpack_checker.sv @@
// Passive checker: predicts unpacker results from accepted words and compares result beats.
`timescale 1ns / 1ps

module aebu_unpack_checker import aebu_pkg::*; #(
  parameter int unsigned MAX_MODULES_PER_KIND = MAX_MODULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  aebu_word_if        evt_i,
  aebu_result_if      res_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);

  // Predictor copy of the configuration.
  logic [2:0]  first_count_q;
  logic [2:0]  second_count_q;
  logic [19:0] first_addr_q;
  logic [31:0] second_addr_q;

  // Predictor copy of the parser.
  phase_e      phase_q;
  logic        kind_q;
  logic [2:0]  slot_q;
  logic [12:0] left_q;
  logic        skip_q;
  logic [11:0] held_q;

  result_t     expected_results[$];
  int unsigned mismatches;

  function automatic logic [2:0] modules_in(logic kind);
    logic [2:0] n;
    n = kind ? second_count_q : first_count_q;
    if (n > MAX_MODULES_PER_KIND) n = 3'(MAX_MODULES_PER_KIND);
    return n;
  endfunction

  // Configured address of a slot; anything shifted past the register reads as zero.
  function automatic logic [7:0] slot_address(logic kind, logic [2:0] slot);
    int unsigned sh;
    if (kind) begin
      sh = 8 * slot;
      return (sh >= 32) ? 8'h00 : 8'(second_addr_q >> sh);
    end
    sh = 5 * slot;
    return (sh >= 20) ? 8'h00 : {3'b000, 5'(first_addr_q >> sh)};
  endfunction

  function automatic void rewind();
    phase_q = PH_HEADER;
    kind_q  = 1'b0;
    slot_q  = 3'd0;
    left_q  = '0;
    skip_q  = 1'b0;
    held_q  = '0;
  endfunction

  // Skip slots that are not configured; past the last second-kind slot the event is done.
  function automatic void settle();
    if (phase_q != PH_HEADER) return;
    if (!kind_q && slot_q >= modules_in(1'b0)) begin
      kind_q = 1'b1;
      slot_q = 3'd0;
    end
    if (kind_q && slot_q >= modules_in(1'b1)) phase_q = PH_DONE;
  endfunction

  function automatic void next_slot();
    slot_q  = slot_q + 3'd1;
    phase_q = PH_HEADER;
    settle();
  endfunction

  function automatic void push_result(logic [4:0] channel, logic [15:0] value, rpt_e code,
                                      logic eoe);
    result_t r;
    r.kind    = kind_q;
    r.slot    = slot_q[1:0];
    r.channel = channel;
    r.value   = value;
    r.code    = code;
    r.eoe     = eoe;
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_word(logic [15:0] w, logic fin);
    logic       consumed;
    logic [7:0] addr;
    rpt_e       status;
    consumed = 1'b1;
    settle();
    case (phase_q)
      PH_HEADER: begin
        if (w == EMPTY_MARK) begin
          phase_q = PH_EMPTY;
        end else begin
          // first kind counts hits (two words each), second kind counts 32-bit words
          left_q  = kind_q ? {w[11:0], 1'b0} : {4'h0, w[15:8], 1'b0};
          phase_q = PH_ADDR;
        end
      end
      PH_EMPTY: next_slot();
      PH_ADDR: begin
        if (kind_q) begin
          addr   = w[7:0];
          left_q = (left_q >= 13'd2) ? left_q - 13'd2 : '0;
        end else begin
          addr = {3'b000, w[15:11]};
        end
        skip_q = (addr != slot_address(kind_q, slot_q));
        if (skip_q) push_result('0, {8'h00, addr}, RPT_MISMATCH, 1'b0);
        phase_q = (left_q != 0) ? PH_VAL : PH_COUNTER;
      end
      PH_VAL: begin
        held_q  = w[11:0];
        if (left_q != 0) left_q = left_q - 13'd1;
        phase_q = PH_CHAN;
      end
      PH_CHAN: begin
        if (left_q != 0) left_q = left_q - 13'd1;
        if (!skip_q) push_result(w[4:0], {4'h0, held_q}, RPT_HIT, 1'b0);
        phase_q = (left_q != 0) ? PH_VAL : PH_COUNTER;
      end
      PH_COUNTER: begin
        push_result('0, w, RPT_COUNTER, 1'b0);
        skip_q  = 1'b0;
        left_q  = 13'd3;
        phase_q = PH_TRAILER;
      end
      PH_TRAILER: begin
        if (left_q != 0) left_q = left_q - 13'd1;
        if (left_q == 0) next_slot();
      end
      default: consumed = 1'b0;
    endcase
    if (fin) begin
      status = (consumed && phase_q == PH_DONE) ? RPT_EVENT_OK : RPT_LEN_ERR;
      kind_q = 1'b0;
      slot_q = 3'd0;
      push_result('0, 16'h0000, status, 1'b1);
      rewind();
    end
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      first_count_q  = '0;
      second_count_q = '0;
      first_addr_q   = '0;
      second_addr_q  = '0;
      rewind();
      expected_results.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FIRST_COUNT:  first_count_q  = cfg_data_i[2:0];
          CFG_SECOND_COUNT: second_count_q = cfg_data_i[2:0];
          CFG_FIRST_ADDR:   first_addr_q   = cfg_data_i[19:0];
          CFG_SECOND_ADDR:  second_addr_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (evt_i.valid && evt_i.ready) predict_word(evt_i.event_word, evt_i.final_word);
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: code %0h value %0h",
                 res_i.report_code, res_i.word_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("module_kind", 16'(want.kind), 16'(res_i.module_kind));
          check_field("module_slot", 16'(want.slot), 16'(res_i.module_slot));
          check_field("channel_number", 16'(want.channel), 16'(res_i.channel_number));
          check_field("word_value", want.value, res_i.word_value);
          check_field("report_code", 16'(want.code), 16'(res_i.report_code));
          check_field("end_of_event", 16'(want.eoe), 16'(res_i.end_of_event));
        end
      end
      pending_o        <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ tb/sv/adc_event_block_unpacker_test.sv @@
// Top of the unpacker testbench: clock, reset, config writes, event word stimulus, verdict.
`timescale 1ns / 1ps

module adc_event_block_unpacker_test;
  import aebu_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int unsigned RANDOM_WORDS   = 1150;
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned DRAIN_CYCLES   = 4;     // word reg + result queue, with margin
  localparam int unsigned MAX_BODY       = 600;   // longer bodies get cut short

  // Directed config: one module of each kind, slot 0 addresses 5'h15 and 8'hA7.
  localparam logic [19:0] DIR_FIRST_ADDR  = 20'h5A3F5;
  localparam logic [31:0] DIR_SECOND_ADDR = 32'h3C96_E1A7;

  // Directed words, {final_word, event_word}.
  localparam logic [16:0] DIRECTED [23] = '{
    // well-formed: first kind with two hits at field extremes, second kind empty
    {1'b0, 16'h0200},  // 2 hits
    {1'b0, 16'hAFFF},  // address 5'h15 matches
    {1'b0, 16'hFFFF},  // value 0xfff
    {1'b0, 16'hFFFF},  // channel 31
    {1'b0, 16'h0000},  // value 0
    {1'b0, 16'h0000},  // channel 0
    {1'b0, 16'hFFFF},  // counter word
    {1'b0, 16'h0000},
    {1'b0, 16'h1234},
    {1'b0, 16'h5678},
    {1'b0, 16'hFFFF},  // empty second-kind module
    {1'b1, 16'h0000},  // skip word closes the event cleanly
    // first kind empty, second kind with a wrong id: data dropped, counter still reported
    {1'b0, 16'hFFFF},
    {1'b0, 16'hFFFF},
    {1'b0, 16'hF002},  // two 32-bit words
    {1'b0, 16'hFFA6},  // id 8'hA6 vs configured 8'hA7
    {1'b0, 16'h1234},
    {1'b0, 16'h0005},
    {1'b0, 16'h00AB},  // counter word
    {1'b0, 16'h0000},
    {1'b0, 16'h0000},
    {1'b1, 16'h0000},
    // body cut short right after a header claiming 255 hits
    {1'b1, 16'hFF00}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  // Idle percentages of the current phase.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // Stimulus-side view of the config, used to build well-formed bodies.
  int unsigned first_modules;
  int unsigned second_modules;
  logic [19:0] first_addrs;
  logic [31:0] second_ids;

  logic [15:0] body_q[$];

  aebu_word_if   word_ch ();
  aebu_result_if res_ch ();

  adc_event_block_unpacker DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .evt_i       (word_ch),
    .res_o       (res_ch)
  );

  aebu_unpack_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .evt_i            (word_ch),
    .res_i            (res_ch),
    .pending_o        (pending),
    .mismatch_count_o (fail_count)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: ready dropped at random per the phase's stall rate.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: restarts on every word or result beat.
  always @(posedge clk) begin
    if ((word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("adc_event_block_unpacker verification failed");
      $finish;
    end
  end

  // One word beat. Valid stays high into the next call when no gap is rolled,
  // so back-to-back beats never lower and raise valid in the same step.
  task automatic put_word(logic [15:0] w, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      word_ch.valid <= 1'b0;
      @(posedge clk);
    end
    word_ch.valid      <= 1'b1;
    word_ch.event_word <= w;
    word_ch.final_word <= fin;
    do @(posedge clk); while (!word_ch.ready);
  endtask

  // Park the word side and wait until every predicted result has come back,
  // then let the word register and result queue settle for words that produce nothing.
  task automatic wait_drained();
    word_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all four registers; unused upper data bits get random junk.
  task automatic load_config(logic [2:0] n_first, logic [2:0] n_second,
                             logic [19:0] a_first, logic [31:0] a_second);
    first_modules  = (n_first > 4) ? 4 : n_first;
    second_modules = (n_second > 4) ? 4 : n_second;
    first_addrs    = a_first;
    second_ids     = a_second;
    write_reg(CFG_FIRST_COUNT, {29'($urandom), n_first});
    write_reg(CFG_SECOND_COUNT, {29'($urandom), n_second});
    write_reg(CFG_FIRST_ADDR, {12'($urandom), a_first});
    write_reg(CFG_SECOND_ADDR, a_second);
    cfg_we <= 1'b0;
  endtask

  // Appends one module: sometimes empty, sometimes with a wrong address,
  // usually a few hits, now and then a large count.
  task automatic append_module(logic kind, int unsigned slot);
    int unsigned pick;
    int unsigned count;
    int unsigned data_words;
    logic [15:0] header;
    logic [7:0]  id;
    logic [4:0]  geo;
    pick = $urandom_range(99);
    if (pick < 12) begin
      body_q = {body_q, EMPTY_MARK};
      body_q = {body_q, 16'($urandom)};
      return;
    end
    if (kind) begin
      count  = ($urandom_range(24) == 0) ? $urandom_range(4095) : $urandom_range(5);
      header = {4'($urandom), 12'(count)};
      if (header == EMPTY_MARK) header[15] = 1'b0;
      data_words = (count > 1) ? 2 * count - 2 : 0;
      id = second_ids[8 * slot +: 8];
      if (pick < 27) id = id ^ 8'(1 + $urandom_range(254));
      body_q = {body_q, header};
      body_q = {body_q, {8'($urandom), id}};
    end else begin
      count  = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(4);
      header = {8'(count), 8'($urandom)};
      if (header == EMPTY_MARK) header[0] = 1'b0;
      data_words = 2 * count;
      geo = first_addrs[5 * slot +: 5];
      if (pick < 27) geo = geo ^ 5'(1 + $urandom_range(30));
      body_q = {body_q, header};
      body_q = {body_q, {geo, 11'($urandom)}};
    end
    repeat (data_words) body_q = {body_q, 16'($urandom)};
    repeat (4) body_q = {body_q, 16'($urandom)};  // counter word and three trailer words
  endtask

  // Builds one body: mostly well-formed, some cut short, some with extra words,
  // and some pure noise.
  task automatic build_event();
    int unsigned style;
    int unsigned keep;
    body_q.delete();
    style = $urandom_range(99);
    if (style < 6) begin
      repeat (1 + $urandom_range(7)) begin
        body_q = {body_q, (($urandom_range(3) == 0) ? EMPTY_MARK : 16'($urandom))};
      end
      return;
    end
    for (int unsigned s = 0; s < first_modules; s++) append_module(1'b0, s);
    for (int unsigned s = 0; s < second_modules; s++) append_module(1'b1, s);
    if (body_q.size() > MAX_BODY) begin
      keep = 1 + $urandom_range(39);
    end else if (style < 16 && body_q.size() >= 2) begin
      keep = 1 + $urandom_range(body_q.size() - 2);
    end else begin
      keep = body_q.size();
    end
    while (body_q.size() > keep) void'(body_q.pop_back());
    if (style >= 16 && style < 24) begin
      repeat (1 + $urandom_range(3)) body_q = {body_q, 16'($urandom)};
    end
    // with no modules configured the body is all extra words
    if (body_q.size() == 0) body_q = {body_q, 16'($urandom)};
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      1:       begin send_idle_pct = 73; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 73; end
      3:       begin send_idle_pct = 21; stall_pct = 21; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin : stimulus
    int unsigned sent;
    rst_n              = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    word_ch.valid      <= 1'b0;
    word_ch.event_word <= '0;
    word_ch.final_word <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    load_config(3'd1, 3'd1, DIR_FIRST_ADDR, DIR_SECOND_ADDR);
    foreach (DIRECTED[i]) put_word(DIRECTED[i][15:0], DIRECTED[i][16]);

    // Random phases: each gets its own config and one of four idling modes; counts past
    // the module limit, zero modules and all-ones addresses are among them.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: load_config(3'd2, 3'd2, 20'($urandom), $urandom);
        1: load_config(3'd4, 3'd4, 20'hFFFFF, 32'hFFFF_FFFF);
        2: load_config(3'd7, 3'd5, 20'($urandom), $urandom);
        3: load_config(3'd0, 3'd0, 20'h00000, 32'h0000_0000);
        4: load_config(3'd1, 3'd0, 20'h00000, $urandom);
        5: load_config(3'd0, 3'd3, 20'($urandom), $urandom);
        default: load_config(3'($urandom), 3'($urandom), 20'($urandom), $urandom);
      endcase
      set_idling(p % 4);
      sent = 0;
      while (sent < RANDOM_WORDS / RANDOM_PHASES) begin
        build_event();
        // the last event of a phase is cut to what is left of the word budget
        while (body_q.size() > RANDOM_WORDS / RANDOM_PHASES - sent) void'(body_q.pop_back());
        foreach (body_q[i]) put_word(body_q[i], i == body_q.size() - 1);
        sent += body_q.size();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("adc_event_block_unpacker verification clean");
    end else begin
      $display("adc_event_block_unpacker verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/aebu_pkg.sv
hdl/aebu_if.sv
hdl/aebu_parser.sv
hdl/aebu_out_queue.sv
hdl/adc_event_block_unpacker.sv
tb/sv/aebu_unpack_checker.sv
tb/sv/adc_event_block_unpacker_test.sv
